// File: rtl/dtf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_pkg
// Shared types, widths and helpers of the depth-tested triangle fill unit.
// ----------------------------------------------------------------------------
package dtf_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 128;

  localparam int OP_W        = 2;
  localparam int CRD_W       = 12;
  localparam int VW_W        = 32;
  localparam int COL_W       = 32;
  localparam int INV_W       = 32;
  localparam int PW_W        = 15;
  localparam int VERT_STRIDE = 2 * CRD_W + VW_W;
  localparam int FILL_LSB    = 3 * VERT_STRIDE;
  localparam int S_TDATA_W   = FILL_LSB + COL_W;
  localparam int M_TDATA_W   = 80;

  localparam int DIFF_W  = CRD_W + 1;
  localparam int SLOPE_W = 29;
  localparam int SPAN_W  = 44;
  localparam int RND_W   = 28;
  localparam int AREA_W  = 27;
  localparam int GC_W    = 29;
  localparam int PROD_W  = 62;
  localparam int ACC_W   = 64;
  localparam int NUM_W   = 64;
  localparam int DEN_W   = 32;
  localparam int QUO_W   = 32;

  localparam logic [PW_W-1:0]  PW_MAX   = '1;
  localparam logic [NUM_W-1:0] INV_NUM  = NUM_W'(1) << 40;

  typedef enum logic [OP_W-1:0] {
    OP_DRAW  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [4:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_READ_DATA,
    ST_INV_GO,
    ST_INV_WAIT,
    ST_SORT,
    ST_AREA,
    ST_CHECK,
    ST_S2_WAIT,
    ST_HALF,
    ST_S1_WAIT,
    ST_ROW_XS,
    ST_ROW_XE,
    ST_ROW_SPAN,
    ST_PIX_BC,
    ST_PIX_AC,
    ST_PIX_GC,
    ST_PIX_M1,
    ST_PIX_M2,
    ST_PIX_SUM,
    ST_PIX_DIV,
    ST_PIX_WAIT,
    ST_PIX_NEXT,
    ST_ROW_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

  // Q28.16 to integer, half away from zero
  function automatic logic signed [RND_W-1:0] round_q16(input logic signed [SPAN_W-1:0] v);
    logic [SPAN_W-1:0] mag;
    logic [SPAN_W-1:0] r;
    mag = v[SPAN_W-1] ? SPAN_W'(-v) : SPAN_W'(v);
    r   = (mag + SPAN_W'(32768)) >> 16;
    return v[SPAN_W-1] ? -$signed(r[RND_W-1:0]) : $signed(r[RND_W-1:0]);
  endfunction

endpackage
`default_nettype wire

// File: rtl/dtf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_div
// Restoring unsigned divider, one quotient bit a cycle, 32-bit saturating
// quotient.
// ----------------------------------------------------------------------------
module dtf_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dtf_pkg::div_req_t req,
  output dtf_pkg::div_rsp_t      rsp
);
  import dtf_pkg::*;

  logic             busy;
  logic             done;
  logic [4:0]       cnt;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsh;
  logic [QUO_W-1:0] quot;
  logic             sat;

  // quotient does not fit in 32 bits (also catches a zero divisor)
  assign sat = req.num >= {req.den, 32'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= '0;
        if (sat) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.num;
      dsh  <= {1'b0, req.den, 31'd0};
      quot <= sat ? '1 : '0;
    end else if (busy) begin
      dsh <= dsh >> 1;
      if (rem >= dsh) begin
        rem  <= rem - dsh;
        quot <= {quot[QUO_W-2:0], 1'b1};
      end else begin
        quot <= {quot[QUO_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule
`default_nettype wire

// File: rtl/depth_tested_triangle_fill_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// depth_tested_triangle_fill_unit
// Flat triangle rasteriser over on-chip colour and inverse-w depth memories.
// ----------------------------------------------------------------------------
// One item at a time. After reset the unit sweeps both memories to zero
// before it takes its first beat; a clear sweeps the memories again. A
// draw runs each of the three vertex inverses and each edge slope through
// the shared bit-serial divider, then walks the visited rows; for each
// covered on-screen pixel the same divider turns the barycentric sum into
// inverse w before the depth read-modify-write.
module depth_tested_triangle_fill_unit #(
  parameter int SCREEN_WIDTH  = dtf_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = dtf_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // vert0_x, vert0_y, vert0_w, vert1_x, vert1_y, vert1_w,
  // vert2_x, vert2_y, vert2_w, fill_colour
  input  wire logic [dtf_pkg::S_TDATA_W-1:0]  s_tdata,
  // opcode
  input  wire logic [dtf_pkg::OP_W-1:0]       s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // pixels_written, pixel_colour, pixel_inverse_w, zero pad
  output logic [dtf_pkg::M_TDATA_W-1:0]       m_tdata,
  // in_range
  output logic                                m_tuser,
  input  wire logic                           cfg_we,
  input  wire logic [dtf_pkg::COL_W-1:0]      cfg_wdata
);
  import dtf_pkg::*;

  localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW     = $clog2(PIXELS);
  localparam int XW     = $clog2(SCREEN_WIDTH + 1);
  localparam int YW     = $clog2(SCREEN_HEIGHT);

  state_t state, state_next;

  // input unpack
  logic signed [CRD_W-1:0] in_vx [3];
  logic signed [CRD_W-1:0] in_vy [3];
  logic        [VW_W-1:0]  in_w  [3];
  opcode_t                 in_op;
  logic                    accept;

  // registers
  logic [COL_W-1:0]        clear_colour;
  logic [COL_W-1:0]        sweep_colour;
  logic                    sweep_reply;
  logic [AW-1:0]           pix_addr;
  opcode_t                 op;
  logic signed [CRD_W-1:0] vx [3];
  logic signed [CRD_W-1:0] vy [3];
  logic        [VW_W-1:0]  vw [3];
  logic        [INV_W-1:0] inv [3];
  logic [COL_W-1:0]        fill;
  logic [1:0]              k;
  logic signed [AREA_W-1:0]  abc;
  logic signed [SLOPE_W-1:0] s1, s2;
  logic                    half;
  logic [YW-1:0]           y, yhi;
  logic signed [SPAN_W-1:0] xs, xe;
  logic [XW-1:0]           x, xhi;
  logic signed [AREA_W-1:0] pbc, apc;
  logic signed [GC_W-1:0]   gcc;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [PW_W-1:0]         pcount;
  logic [COL_W-1:0]        res_col;
  logic [INV_W-1:0]        res_inv;
  logic                    res_in;
  logic                    rd_in;
  logic [PW_W-1:0]         out_pw;
  logic [COL_W-1:0]        out_col;
  logic [INV_W-1:0]        out_inv;
  logic                    out_in;

  // memories
  logic [COL_W-1:0]        colour_mem [PIXELS];
  logic [INV_W-1:0]        depth_mem  [PIXELS];
  logic [COL_W-1:0]        colour_q;
  logic [INV_W-1:0]        depth_q;
  logic                    mem_we;
  logic [COL_W-1:0]        wr_colour;
  logic [INV_W-1:0]        wr_depth;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // combinational helpers
  logic signed [CRD_W-1:0]  srt_x [3];
  logic signed [CRD_W-1:0]  srt_y [3];
  logic        [INV_W-1:0]  srt_i [3];
  logic signed [AREA_W-1:0] abc_calc;
  logic signed [DIFF_W-1:0] ya, yb, xa, xb, dy_half, dx_half, dx02, dy02;
  logic signed [DIFF_W-1:0] ylo_s, yhi_s, y13, x13;
  logic                     rows_empty;
  logic signed [RND_W-1:0]  r_lo, r_hi;
  logic [XW-1:0]            xlo_c, xhi_c;
  logic signed [GC_W-1:0]   mul_a;
  logic signed [INV_W:0]    mul_b;
  logic [DIFF_W-1:0]        dx_mag;
  logic                     acc_ok;
  logic                     load_out;
  logic                     rd_ok;
  logic signed [SLOPE_W-1:0] q_slope;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_vx[i] = s_tdata[VERT_STRIDE*i +: CRD_W];
      in_vy[i] = s_tdata[VERT_STRIDE*i + CRD_W +: CRD_W];
      in_w[i]  = s_tdata[VERT_STRIDE*i + 2*CRD_W +: VW_W];
    end
  end
  assign in_op  = opcode_t'(s_tuser);
  assign accept = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);

  assign rd_ok = !in_vx[0][CRD_W-1] && !in_vy[0][CRD_W-1] &&
                 ($signed(DIFF_W'(in_vx[0])) < $signed(DIFF_W'(SCREEN_WIDTH))) &&
                 ($signed(DIFF_W'(in_vy[0])) < $signed(DIFF_W'(SCREEN_HEIGHT)));

  // three compare-and-swap steps on strict row order
  always_comb begin
    logic signed [CRD_W-1:0] tx, ty;
    logic        [INV_W-1:0] ti;
    tx = '0;
    ty = '0;
    ti = '0;
    srt_x = vx;
    srt_y = vy;
    srt_i = inv;
    if (srt_y[0] > srt_y[1]) begin
      tx = srt_x[0]; srt_x[0] = srt_x[1]; srt_x[1] = tx;
      ty = srt_y[0]; srt_y[0] = srt_y[1]; srt_y[1] = ty;
      ti = srt_i[0]; srt_i[0] = srt_i[1]; srt_i[1] = ti;
    end
    if (srt_y[1] > srt_y[2]) begin
      tx = srt_x[1]; srt_x[1] = srt_x[2]; srt_x[2] = tx;
      ty = srt_y[1]; srt_y[1] = srt_y[2]; srt_y[2] = ty;
      ti = srt_i[1]; srt_i[1] = srt_i[2]; srt_i[2] = ti;
    end
    if (srt_y[0] > srt_y[1]) begin
      tx = srt_x[0]; srt_x[0] = srt_x[1]; srt_x[1] = tx;
      ty = srt_y[0]; srt_y[0] = srt_y[1]; srt_y[1] = ty;
      ti = srt_i[0]; srt_i[0] = srt_i[1]; srt_i[1] = ti;
    end
  end

  assign dx02 = DIFF_W'(vx[2]) - DIFF_W'(vx[0]);
  assign dy02 = DIFF_W'(vy[2]) - DIFF_W'(vy[0]);
  assign abc_calc = AREA_W'(dx02) * AREA_W'(DIFF_W'(vy[1]) - DIFF_W'(vy[0]))
                  - AREA_W'(dy02) * AREA_W'(DIFF_W'(vx[1]) - DIFF_W'(vx[0]));

  // current half: upper runs v0..v1, lower v1..v2
  assign ya = half ? DIFF_W'(vy[1]) : DIFF_W'(vy[0]);
  assign yb = half ? DIFF_W'(vy[2]) : DIFF_W'(vy[1]);
  assign xa = half ? DIFF_W'(vx[1]) : DIFF_W'(vx[0]);
  assign xb = half ? DIFF_W'(vx[2]) : DIFF_W'(vx[1]);
  assign dy_half = yb - ya;
  assign dx_half = xb - xa;
  assign ylo_s = ya[DIFF_W-1] ? '0 : ya;
  assign yhi_s = (yb > $signed(DIFF_W'(SCREEN_HEIGHT - 1))) ?
                 $signed(DIFF_W'(SCREEN_HEIGHT - 1)) : yb;
  assign rows_empty = ylo_s > yhi_s;

  assign y13 = $signed({{(DIFF_W-YW){1'b0}}, y});
  assign x13 = $signed({{(DIFF_W-XW){1'b0}}, x});

  // span ends, rounded and clipped to the screen
  always_comb begin
    logic signed [SPAN_W-1:0] lo, hi;
    lo = (xe < xs) ? xe : xs;
    hi = (xe < xs) ? xs : xe;
    r_lo = round_q16(lo);
    r_hi = round_q16(hi);
    if (r_lo[RND_W-1])
      xlo_c = '0;
    else if (r_lo > $signed(RND_W'(SCREEN_WIDTH)))
      xlo_c = XW'(SCREEN_WIDTH);
    else
      xlo_c = r_lo[XW-1:0];
    if (r_hi[RND_W-1])
      xhi_c = '0;
    else if (r_hi > $signed(RND_W'(SCREEN_WIDTH)))
      xhi_c = XW'(SCREEN_WIDTH);
    else
      xhi_c = r_hi[XW-1:0];
  end

  // one multiplier for the three barycentric products
  always_comb begin
    case (state)
      ST_PIX_M1: begin
        mul_a = GC_W'(apc);
        mul_b = $signed({1'b0, inv[1]});
      end
      ST_PIX_M2: begin
        mul_a = gcc;
        mul_b = $signed({1'b0, inv[2]});
      end
      default: begin
        mul_a = GC_W'(pbc);
        mul_b = $signed({1'b0, inv[0]});
      end
    endcase
  end

  assign acc_ok  = (acc != '0) && (acc[ACC_W-1] == abc[AREA_W-1]);
  assign q_slope = $signed({1'b0, div_rsp.quot[SLOPE_W-2:0]});

  always_comb begin
    case (state)
      ST_CHECK:
        dx_mag = dx02[DIFF_W-1] ? DIFF_W'(-dx02) : DIFF_W'(dx02);
      default:
        dx_mag = dx_half[DIFF_W-1] ? DIFF_W'(-dx_half) : DIFF_W'(dx_half);
    endcase
  end

  // divider requests
  always_comb begin
    div_req = '0;
    case (state)
      ST_INV_GO: begin
        div_req.start = 1'b1;
        div_req.num   = INV_NUM;
        div_req.den   = vw[k];
      end
      ST_CHECK: begin
        div_req.start = (abc != '0);
        div_req.num   = NUM_W'({dx_mag, 16'd0});
        div_req.den   = DEN_W'($unsigned(dy02));
      end
      ST_HALF: begin
        div_req.start = (dy_half != '0);
        div_req.num   = NUM_W'({dx_mag, 16'd0});
        div_req.den   = DEN_W'($unsigned(dy_half));
      end
      ST_PIX_DIV: begin
        div_req.start = acc_ok;
        div_req.num   = acc[ACC_W-1] ? NUM_W'(-acc) : NUM_W'(acc);
        div_req.den   = abc[AREA_W-1] ? DEN_W'(-abc) : DEN_W'(abc);
      end
      default: div_req = '0;
    endcase
  end

  dtf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign load_out = (state == ST_DONE) && (!m_tvalid || m_tready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP:
        if (pix_addr == AW'(PIXELS - 1))
          state_next = sweep_reply ? ST_DONE : ST_IDLE;
      ST_IDLE:
        if (accept) begin
          case (in_op)
            OP_DRAW:  state_next = ST_INV_GO;
            OP_READ:  state_next = ST_READ;
            OP_CLEAR: state_next = ST_SWEEP;
            default:  state_next = ST_DONE;
          endcase
        end
      ST_READ:      state_next = ST_READ_DATA;
      ST_READ_DATA: state_next = ST_DONE;
      ST_INV_GO:    state_next = ST_INV_WAIT;
      ST_INV_WAIT:
        if (div_rsp.done)
          state_next = (k == 2'd2) ? ST_SORT : ST_INV_GO;
      ST_SORT:      state_next = ST_AREA;
      ST_AREA:      state_next = ST_CHECK;
      ST_CHECK:     state_next = (abc == '0) ? ST_DONE : ST_S2_WAIT;
      ST_S2_WAIT:
        if (div_rsp.done)
          state_next = ST_HALF;
      ST_HALF:
        if (dy_half != '0)
          state_next = ST_S1_WAIT;
        else if (half)
          state_next = ST_DONE;
      ST_S1_WAIT:
        if (div_rsp.done) begin
          if (!rows_empty)
            state_next = ST_ROW_XS;
          else
            state_next = half ? ST_DONE : ST_HALF;
        end
      ST_ROW_XS:    state_next = ST_ROW_XE;
      ST_ROW_XE:    state_next = ST_ROW_SPAN;
      ST_ROW_SPAN:  state_next = (xlo_c < xhi_c) ? ST_PIX_BC : ST_ROW_END;
      ST_PIX_BC:    state_next = ST_PIX_AC;
      ST_PIX_AC:    state_next = ST_PIX_GC;
      ST_PIX_GC:    state_next = ST_PIX_M1;
      ST_PIX_M1:    state_next = ST_PIX_M2;
      ST_PIX_M2:    state_next = ST_PIX_SUM;
      ST_PIX_SUM:   state_next = ST_PIX_DIV;
      ST_PIX_DIV:   state_next = acc_ok ? ST_PIX_WAIT : ST_PIX_NEXT;
      ST_PIX_WAIT:
        if (div_rsp.done)
          state_next = ST_PIX_NEXT;
      ST_PIX_NEXT:
        state_next = (XW'(x + 1'b1) == xhi) ? ST_ROW_END : ST_PIX_BC;
      ST_ROW_END:
        if (y != yhi)
          state_next = ST_ROW_XS;
        else
          state_next = half ? ST_DONE : ST_HALF;
      ST_DONE:
        if (load_out)
          state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // memory write: sweep, or a pixel that wins the depth test
  always_comb begin
    mem_we    = 1'b0;
    wr_colour = fill;
    wr_depth  = div_rsp.quot;
    if (state == ST_SWEEP) begin
      mem_we    = 1'b1;
      wr_colour = sweep_colour;
      wr_depth  = '0;
    end else if (state == ST_PIX_WAIT && div_rsp.done && div_rsp.quot > depth_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      colour_mem[pix_addr] <= wr_colour;
      depth_mem[pix_addr]  <= wr_depth;
    end
    colour_q <= colour_mem[pix_addr];
    depth_q  <= depth_mem[pix_addr];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SWEEP;
      clear_colour <= '0;
      sweep_colour <= '0;
      sweep_reply  <= 1'b0;
      pix_addr     <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we)
        clear_colour <= cfg_wdata;
      if (load_out)
        m_tvalid <= 1'b1;
      else if (m_tready)
        m_tvalid <= 1'b0;
      case (state)
        ST_SWEEP:
          pix_addr <= pix_addr + 1'b1;
        ST_IDLE:
          if (accept) begin
            if (in_op == OP_CLEAR) begin
              sweep_colour <= clear_colour;
              sweep_reply  <= 1'b1;
              pix_addr     <= '0;
            end else if (in_op == OP_READ) begin
              pix_addr <= AW'(in_vy[0][YW-1:0]) * AW'(SCREEN_WIDTH)
                        + AW'(in_vx[0][XW-1:0]);
            end
          end
        ST_ROW_SPAN:
          pix_addr <= AW'(y) * AW'(SCREEN_WIDTH) + AW'(xlo_c);
        ST_PIX_NEXT:
          pix_addr <= pix_addr + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE:
        if (accept) begin
          op      <= in_op;
          vx      <= in_vx;
          vy      <= in_vy;
          vw      <= in_w;
          fill    <= s_tdata[FILL_LSB +: COL_W];
          k       <= '0;
          pcount  <= '0;
          rd_in   <= rd_ok;
          res_col <= '0;
          res_inv <= '0;
          res_in  <= 1'b0;
        end
      ST_READ_DATA: begin
        res_in  <= rd_in;
        res_col <= rd_in ? colour_q : '0;
        res_inv <= rd_in ? depth_q : '0;
      end
      ST_INV_WAIT:
        if (div_rsp.done) begin
          inv[k] <= div_rsp.quot;
          k      <= k + 2'd1;
        end
      ST_SORT: begin
        vx  <= srt_x;
        vy  <= srt_y;
        inv <= srt_i;
      end
      ST_AREA:
        abc <= abc_calc;
      ST_S2_WAIT:
        if (div_rsp.done) begin
          s2   <= dx02[DIFF_W-1] ? -q_slope : q_slope;
          half <= 1'b0;
        end
      ST_HALF:
        if (dy_half == '0)
          half <= 1'b1;
      ST_S1_WAIT:
        if (div_rsp.done) begin
          s1 <= dx_half[DIFF_W-1] ? -q_slope : q_slope;
          y  <= ylo_s[YW-1:0];
          yhi <= yhi_s[YW-1:0];
          if (rows_empty)
            half <= 1'b1;
        end
      ST_ROW_XS:
        xs <= (SPAN_W'(vx[1]) <<< 16)
            + SPAN_W'(y13 - DIFF_W'(vy[1])) * SPAN_W'(s1);
      ST_ROW_XE:
        xe <= (SPAN_W'(vx[0]) <<< 16)
            + SPAN_W'(y13 - DIFF_W'(vy[0])) * SPAN_W'(s2);
      ST_ROW_SPAN: begin
        x   <= xlo_c;
        xhi <= xhi_c;
      end
      ST_PIX_BC:
        pbc <= AREA_W'(DIFF_W'(vx[2]) - x13) * AREA_W'(DIFF_W'(vy[1]) - y13)
             - AREA_W'(DIFF_W'(vy[2]) - y13) * AREA_W'(DIFF_W'(vx[1]) - x13);
      ST_PIX_AC:
        apc <= AREA_W'(dx02) * AREA_W'(y13 - DIFF_W'(vy[0]))
             - AREA_W'(dy02) * AREA_W'(x13 - DIFF_W'(vx[0]));
      ST_PIX_GC: begin
        gcc  <= GC_W'(abc) - GC_W'(pbc) - GC_W'(apc);
        prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      ST_PIX_M1: begin
        acc  <= ACC_W'(prod);
        prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      ST_PIX_M2: begin
        acc  <= acc + ACC_W'(prod);
        prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      ST_PIX_SUM:
        acc <= acc + ACC_W'(prod);
      ST_PIX_WAIT:
        if (mem_we && pcount != PW_MAX)
          pcount <= pcount + 1'b1;
      ST_PIX_NEXT:
        x <= x + 1'b1;
      ST_ROW_END:
        if (y != yhi)
          y <= y + 1'b1;
        else
          half <= 1'b1;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pw  <= (op == OP_DRAW) ? pcount : '0;
      out_col <= res_col;
      out_inv <= res_inv;
      out_in  <= res_in;
    end
  end

  assign m_tdata = {1'b0, out_inv, out_col, out_pw};
  assign m_tuser = out_in;

endmodule
`default_nettype wire

// File: rtl/dtf_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_check
// Port-level checks of the triangle fill unit, bound to the top level.
// ----------------------------------------------------------------------------
module dtf_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [79:0] m_tdata,
  input wire logic        m_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // an on-screen read result carries no pixel count
  a_read_no_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[14:0] == 15'd0)
    else $error("pixel count on a read result");

  // stored values only come back for an on-screen read
  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[78:15] == 64'd0)
    else $error("pixel data without in_range");

  // the clearing pass holds off input after reset
  a_sweep_after_reset: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input taken during clearing pass");

endmodule

bind depth_tested_triangle_fill_unit dtf_check u_dtf_check (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the depth-tested triangle fill unit. Draw, read,
// clear and no-op beats are streamed in with random gaps; a scoreboard keeps
// its own colour and inverse-w stores, predicts every result beat and
// compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import dtf_pkg::*;

  localparam int SW       = SCREEN_WIDTH_DEF;
  localparam int SH       = SCREEN_HEIGHT_DEF;
  localparam int NPIX     = SW * SH;
  localparam int N_RANDOM = 440;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef struct packed {
    logic [COL_W-1:0] fill;
    logic [VW_W-1:0]  w2;
    logic [CRD_W-1:0] y2;
    logic [CRD_W-1:0] x2;
    logic [VW_W-1:0]  w1;
    logic [CRD_W-1:0] y1;
    logic [CRD_W-1:0] x1;
    logic [VW_W-1:0]  w0;
    logic [CRD_W-1:0] y0;
    logic [CRD_W-1:0] x0;
  } tri_beat_t;

  typedef struct {
    logic [PW_W-1:0]  written;
    logic [COL_W-1:0] colour;
    logic [INV_W-1:0] inv_w;
    logic             on_screen;
  } pixel_result_t;

  class fill_scoreboard;
    logic [COL_W-1:0] colour_mem [NPIX];
    logic [INV_W-1:0] depth_mem [NPIX];
    logic [COL_W-1:0] clear_colour;
    pixel_result_t    expected_q[$];
    int               errors;
    int               written;

    function new();
      foreach (colour_mem[i]) begin
        colour_mem[i] = '0;
        depth_mem[i]  = '0;
      end
      clear_colour = '0;
      errors = 0;
    endfunction

    function longint round_q16(longint v);
      if (v >= 0) return (v + 32768) / 65536;
      return -((-v + 32768) / 65536);
    endfunction

    function longint slope(longint dx, longint dy);
      if (dy == 0) return 0;
      return (dx * 65536) / dy;
    endfunction

    function longint vert_inverse(logic [VW_W-1:0] w);
      longint unsigned q;
      if (w == 0) return 64'hFFFFFFFF;
      q = (64'd1 << 40) / {32'd0, w};
      if (q > 64'hFFFFFFFF) q = 64'hFFFFFFFF;
      return longint'(q);
    endfunction

    function void fill_rows(longint ya, longint yb, longint vx[3], longint vy[3],
                            longint s1, longint s2, longint inv[3], longint abc,
                            logic [COL_W-1:0] col);
      longint ylo, yhi, xs, xe, t, xlo, xhi, pbc, apc, gcc, q;
      int idx;
      ylo = ya < 0 ? 0 : ya;
      yhi = yb > SH - 1 ? SH - 1 : yb;
      for (longint y = ylo; y <= yhi; y++) begin
        xs = vx[1] * 65536 + (y - vy[1]) * s1;
        xe = vx[0] * 65536 + (y - vy[0]) * s2;
        if (xe < xs) begin
          t = xs; xs = xe; xe = t;
        end
        xlo = round_q16(xs);
        xhi = round_q16(xe);
        if (xlo < 0) xlo = 0;
        if (xhi > SW) xhi = SW;
        for (longint x = xlo; x < xhi; x++) begin
          pbc = (vx[2] - x) * (vy[1] - y) - (vy[2] - y) * (vx[1] - x);
          apc = (vx[2] - vx[0]) * (y - vy[0]) - (vy[2] - vy[0]) * (x - vx[0]);
          gcc = abc - pbc - apc;
          q = (pbc * inv[0] + apc * inv[1] + gcc * inv[2]) / abc;
          if (q < 0) q = 0;
          if (q > 64'sh FFFFFFFF) q = 64'hFFFFFFFF;
          idx = int'(y * SW + x);
          if (q[31:0] > depth_mem[idx]) begin
            colour_mem[idx] = col;
            depth_mem[idx]  = q[31:0];
            if (written < 32767) written++;
          end
        end
      end
    endfunction

    function void rasterise(tri_beat_t b);
      longint vx[3], vy[3], inv[3], abc, s1, s2, t;
      int ia, ib;
      vx[0] = longint'($signed(b.x0)); vy[0] = longint'($signed(b.y0));
      vx[1] = longint'($signed(b.x1)); vy[1] = longint'($signed(b.y1));
      vx[2] = longint'($signed(b.x2)); vy[2] = longint'($signed(b.y2));
      inv[0] = vert_inverse(b.w0);
      inv[1] = vert_inverse(b.w1);
      inv[2] = vert_inverse(b.w2);
      // sort by row: 0-1, 1-2, 0-1
      for (int k = 0; k < 3; k++) begin
        ia = (k == 1) ? 1 : 0;
        ib = ia + 1;
        if (vy[ia] > vy[ib]) begin
          t = vx[ia]; vx[ia] = vx[ib]; vx[ib] = t;
          t = vy[ia]; vy[ia] = vy[ib]; vy[ib] = t;
          t = inv[ia]; inv[ia] = inv[ib]; inv[ib] = t;
        end
      end
      abc = (vx[2] - vx[0]) * (vy[1] - vy[0]) - (vy[2] - vy[0]) * (vx[1] - vx[0]);
      if (abc == 0) return;
      s2 = slope(vx[2] - vx[0], vy[2] - vy[0]);
      if (vy[1] != vy[0]) begin
        s1 = slope(vx[1] - vx[0], vy[1] - vy[0]);
        fill_rows(vy[0], vy[1], vx, vy, s1, s2, inv, abc, b.fill);
      end
      if (vy[2] != vy[1]) begin
        s1 = slope(vx[2] - vx[1], vy[2] - vy[1]);
        fill_rows(vy[1], vy[2], vx, vy, s1, s2, inv, abc, b.fill);
      end
    endfunction

    function void note_beat(opcode_t op, tri_beat_t b);
      pixel_result_t r;
      longint px, py;
      int idx;
      r = '{default: '0};
      case (op)
        OP_DRAW: begin
          written = 0;
          rasterise(b);
          r.written = written[PW_W-1:0];
        end
        OP_READ: begin
          px = longint'($signed(b.x0));
          py = longint'($signed(b.y0));
          if (px >= 0 && px < SW && py >= 0 && py < SH) begin
            idx = int'(py * SW + px);
            r.colour    = colour_mem[idx];
            r.inv_w     = depth_mem[idx];
            r.on_screen = 1'b1;
          end
        end
        OP_CLEAR: begin
          foreach (colour_mem[i]) begin
            colour_mem[i] = clear_colour;
            depth_mem[i]  = '0;
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] d, logic u);
      pixel_result_t e;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (d[PW_W-1:0] !== e.written) begin
        $error("pixels_written: expected %0d, got %0d", e.written, d[PW_W-1:0]);
        errors++;
      end
      if (d[PW_W +: COL_W] !== e.colour) begin
        $error("pixel_colour: expected %h, got %h", e.colour, d[PW_W +: COL_W]);
        errors++;
      end
      if (d[PW_W+COL_W +: INV_W] !== e.inv_w) begin
        $error("pixel_inverse_w: expected %h, got %h", e.inv_w, d[PW_W+COL_W +: INV_W]);
        errors++;
      end
      if (u !== e.on_screen) begin
        $error("in_range: expected %0d, got %0d", e.on_screen, u);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [OP_W-1:0]      s_tuser = OP_NOP;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 cfg_we = 1'b0;
  logic [COL_W-1:0]     cfg_wdata = '0;

  fill_scoreboard sb = new();
  int     beats_in = 0;
  int     beats_out = 0;
  int     holdoff = 0;
  longint cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  depth_tested_triangle_fill_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  function automatic bit quiet_stretch();
    return beats_in >= 200 && beats_in < 300;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata, m_tuser);
      beats_out <= beats_out + 1;
    end
  end

  // receiver: random stalls, one long hold-off part way through
  always @(negedge clk) begin
    if (beats_out == 120 && holdoff == 0 && m_tready) begin
      holdoff <= 3000;
      m_tready <= 1'b0;
    end else if (holdoff > 1) begin
      holdoff <= holdoff - 1;
      m_tready <= 1'b0;
    end else begin
      if (holdoff == 1) holdoff <= -1;
      m_tready <= quiet_stretch() || ($urandom_range(99) >= 32);
    end
  end

  task automatic send_beat(opcode_t op, tri_beat_t b);
    while (!quiet_stretch() && $urandom_range(99) < 32) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    sb.note_beat(op, b);
    beats_in++;
  endtask

  task automatic write_clear_colour(logic [COL_W-1:0] v);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.clear_colour = v;
  endtask

  function automatic tri_beat_t make_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                         logic [31:0] wa, logic [31:0] wb, logic [31:0] wc,
                                         logic [31:0] col);
    tri_beat_t b;
    b.x0 = CRD_W'(ax); b.y0 = CRD_W'(ay); b.w0 = wa;
    b.x1 = CRD_W'(bx); b.y1 = CRD_W'(by); b.w1 = wb;
    b.x2 = CRD_W'(cx); b.y2 = CRD_W'(cy); b.w2 = wc;
    b.fill = col;
    return b;
  endfunction

  task automatic read_at(int x, int y);
    tri_beat_t b;
    b = tri_beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    b.x0 = CRD_W'(x);
    b.y0 = CRD_W'(y);
    send_beat(OP_READ, b);
  endtask

  function automatic int rnd_coord();
    return $signed(CRD_W'($urandom));
  endfunction

  function automatic logic [31:0] rnd_w();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(32'h0000_0100, 32'h0000_FFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_beat();
    int sel, bx, by, ax, ay;
    tri_beat_t b;
    sel = $urandom_range(99);
    if (sel < 50) begin
      // small triangle near or on the screen, then sometimes probe near its first vertex
      bx = $urandom_range(SW + 7) - 4;
      by = $urandom_range(SH + 7) - 4;
      b = make_tri(bx, by, bx + $urandom_range(12) - 6, by + $urandom_range(12) - 6,
                   bx + $urandom_range(12) - 6, by + $urandom_range(12) - 6,
                   rnd_w(), rnd_w(), rnd_w(), $urandom);
      send_beat(OP_DRAW, b);
      if ($urandom_range(1)) read_at(bx + $urandom_range(4) - 2, by + $urandom_range(4) - 2);
    end else if (sel < 62) begin
      // far triangle: full-range coordinates, kept off one side of the screen
      b = tri_beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      b.w0 = rnd_w(); b.w1 = rnd_w(); b.w2 = rnd_w();
      case ($urandom_range(3))
        0: begin b.y0[11] = 1'b1; b.y1[11] = 1'b1; b.y2[11] = 1'b1; end
        1: begin b.x0[11] = 1'b1; b.x1[11] = 1'b1; b.x2[11] = 1'b1; end
        2: begin
          b.y0 = CRD_W'($urandom_range(2047, SH)); b.y1 = CRD_W'($urandom_range(2047, SH));
          b.y2 = CRD_W'($urandom_range(2047, SH));
        end
        default: begin
          b.x0 = CRD_W'($urandom_range(2047, SW)); b.x1 = CRD_W'($urandom_range(2047, SW));
          b.x2 = CRD_W'($urandom_range(2047, SW));
        end
      endcase
      send_beat(OP_DRAW, b);
    end else if (sel < 92) begin
      if ($urandom_range(9) == 0) read_at(rnd_coord(), rnd_coord());
      else read_at($urandom_range(SW - 1), $urandom_range(SH - 1));
    end else begin
      b = tri_beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      send_beat(OP_NOP, b);
    end
  endtask

  initial begin
    logic [COL_W-1:0] colours [4];
    tri_beat_t        b;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_clear_colour(32'hFFFF_FFFF);
    // directed: ordinary, zero w, maximum w, flat halves, clipped edges
    send_beat(OP_DRAW, make_tri(10, 10, 20, 14, 12, 22, 32'h0001_0000, 32'h0002_0000,
                                32'h0000_8000, 32'h1111_1111));
    read_at(14, 14);
    send_beat(OP_DRAW, make_tri(12, 12, 18, 16, 13, 20, 32'h0, 32'h0001_0000,
                                32'hFFFF_FFFF, 32'h2222_2222));
    read_at(14, 15);
    send_beat(OP_DRAW, make_tri(30, 30, 40, 30, 35, 38, 32'h0001_0000, 32'h0001_0000,
                                32'h0001_0000, 32'h3333_3333));
    send_beat(OP_DRAW, make_tri(50, 40, 45, 48, 55, 48, 32'h0003_0000, 32'h0001_0000,
                                32'h0002_0000, 32'h4444_4444));
    read_at(50, 46);
    // degenerate: collinear vertices
    send_beat(OP_DRAW, make_tri(60, 60, 64, 64, 68, 68, 32'h0001_0000, 32'h0001_0000,
                                32'h0001_0000, 32'h5555_5555));
    read_at(64, 64);
    // clipped at the top left and bottom right corners
    send_beat(OP_DRAW, make_tri(-5, -4, 6, 2, 1, 7, 32'h0001_0000, 32'h0004_0000,
                                32'h0000_4000, 32'hAAAA_AAAA));
    read_at(0, 0);
    send_beat(OP_DRAW, make_tri(123, 121, 133, 127, 126, 134, 32'h0001_0000, 32'h0001_0000,
                                32'h0001_0000, 32'hFFFF_FFFF));
    read_at(127, 127);
    // extreme coordinates, entirely off screen
    send_beat(OP_DRAW, make_tri(-2048, -2048, 2047, -2048, -2048, -1, 32'hFFFF_FFFF,
                                32'h0, 32'h1, 32'h0));
    send_beat(OP_DRAW, make_tri(2047, 2047, -2048, 2047, 2047, 128, 32'h1, 32'h0,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // depth test: same triangle again writes nothing
    send_beat(OP_DRAW, make_tri(10, 10, 20, 14, 12, 22, 32'h0001_0000, 32'h0002_0000,
                                32'h0000_8000, 32'h6666_6666));
    read_at(-1, 5);
    read_at(5, 128);
    read_at(2047, -2048);
    read_at(-2048, 2047);
    b = tri_beat_t'({7{32'hFFFF_FFFF}});
    send_beat(OP_NOP, b);
    send_beat(OP_CLEAR, b);
    read_at(14, 14);

    colours[0] = 32'h0;
    colours[1] = $urandom;
    colours[2] = 32'hFFFF_FFFF;
    colours[3] = $urandom;
    for (int ph = 0; ph < 4; ph++) begin
      write_clear_colour(colours[ph]);
      b = tri_beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      send_beat(OP_CLEAR, b);
      for (int n = 0; n < N_RANDOM / 4; n++) random_beat();
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
